// ===== design/usbdc_pkg.sv =====
// Package of the USB device controller register block.
// Holds the word types, command codes, register offsets and reset values.
// Used by usbdc_regfile and usb_device_controller_regs_top.
`default_nettype none

package usbdc_pkg;

    // Command codes of an input word.
    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_WRITE     = 3'd1;
    localparam logic [2:0] CMD_ATTACH    = 3'd2;
    localparam logic [2:0] CMD_DETACH    = 3'd3;
    localparam logic [2:0] CMD_SETUP     = 3'd4;
    localparam logic [2:0] CMD_DATA_OUT  = 3'd5;

    // Register map, byte offsets in the 4 KiB window.
    localparam logic [11:0] OFF_CAPS        = 12'h124;
    localparam logic [11:0] OFF_COMMAND     = 12'h140;
    localparam logic [11:0] OFF_STATUS      = 12'h144;
    localparam logic [11:0] OFF_INT_ENABLE  = 12'h148;
    localparam logic [11:0] OFF_LIST_ADDR   = 12'h158;
    localparam logic [11:0] OFF_PORT        = 12'h184;
    localparam logic [11:0] OFF_MODE        = 12'h1A8;
    localparam logic [11:0] OFF_SETUP_STAT  = 12'h1AC;
    localparam logic [11:0] OFF_PRIME       = 12'h1B0;
    localparam logic [11:0] OFF_FLUSH       = 12'h1B4;
    localparam logic [11:0] OFF_EP_STATUS   = 12'h1B8;
    localparam logic [11:0] OFF_EP_COMPLETE = 12'h1BC;
    localparam logic [11:0] OFF_EP_CTRL0    = 12'h1C0;
    localparam logic [11:0] OFF_EP_CTRL1    = 12'h1C4;
    localparam logic [11:0] OFF_EP_CTRL2    = 12'h1C8;

    // Constant read value and reset values.
    localparam logic [31:0] CAPS_VALUE      = 32'h0000_0083;
    localparam logic [31:0] COMMAND_RESET   = 32'h0008_0000;
    localparam logic [31:0] PORT_DEFAULT    = 32'h0900_0204;
    localparam logic [31:0] MODE_RESET      = 32'h0001_5002;
    localparam logic [31:0] EP_CTRL0_RESET  = 32'h0080_0080;

    // Write masks, status and port bits, endpoint masks and the setup offset.
    localparam logic [31:0] PORT_RO_MASK    = 32'h2C00_0F81;
    localparam logic [31:0] CTRL0_RO_MASK   = 32'h0080_0080;
    localparam logic [31:0] STATUS_W_IGNORE = 32'h0001_0010;
    localparam logic [31:0] STATUS_LOAD_BIT = 32'h0000_0100;
    localparam logic [31:0] STATUS_USB_INT  = 32'h0000_0001;
    localparam logic [31:0] STATUS_PORT_CHG = 32'h0000_0004;
    localparam logic [31:0] PORT_CONNECT    = 32'h0000_0001;
    localparam logic [31:0] EP_RX_MASK      = 32'h0000_007F;
    localparam logic [31:0] EP_TX_MASK      = 32'h007F_0000;
    localparam logic [31:0] SETUP_OFFSET    = 32'd40;

    // One input word.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [11:0] reg_offset;
        logic [31:0] wdata;
        logic [3:0]  endpoint;
        logic [7:0]  req_type;
        logic [7:0]  request_code;
        logic [15:0] setup_value;
        logic [15:0] setup_index;
        logic [15:0] setup_length;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
        logic        attach_ack;
        logic [6:0]  prime_tx_mask;
        logic [6:0]  prime_rx_mask;
        logic        prime_refused;
        logic        setup_valid;
        logic [31:0] setup_address;
        logic [31:0] setup_word_lo;
        logic [31:0] setup_word_hi;
        logic        empty_ctrl_reply;
    } t_result;

endpackage

`default_nettype wire

// ===== design/usbdc_regfile.sv =====
// Register file of the USB device controller with its update logic.
// Computes the result word and the next register state for one input word.
// Depends on usbdc_pkg.
`default_nettype none

module usbdc_regfile (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire usbdc_pkg::t_item  i_item,
    output usbdc_pkg::t_result     o_result
);
    import usbdc_pkg::*;

    logic [31:0] r_command,     n_command;
    logic [31:0] r_status,      n_status;
    logic [31:0] r_int_enable,  n_int_enable;
    logic [31:0] r_list_addr,   n_list_addr;
    logic [31:0] r_port,        n_port;
    logic [31:0] r_mode,        n_mode;
    logic [31:0] r_setup_stat,  n_setup_stat;
    logic [31:0] r_ep_status,   n_ep_status;
    logic [31:0] r_ep_complete, n_ep_complete;
    logic [31:0] r_ep_ctrl0,    n_ep_ctrl0;
    logic [31:0] r_ep_ctrl1,    n_ep_ctrl1;
    logic [31:0] r_ep_ctrl2,    n_ep_ctrl2;
    logic        r_running,     n_running;
    logic        r_attached,    n_attached;

    logic [31:0] rd_data;
    logic [31:0] status_wmask;
    logic        link_up;
    t_result     res;

    assign status_wmask = i_item.wdata & ~STATUS_W_IGNORE;
    assign link_up      = r_running && r_attached;

    // Read data multiplexer.
    always_comb begin
        case (i_item.reg_offset)
            OFF_CAPS:        rd_data = CAPS_VALUE;
            OFF_COMMAND:     rd_data = r_command;
            OFF_STATUS:      rd_data = r_status;
            OFF_INT_ENABLE:  rd_data = r_int_enable;
            OFF_LIST_ADDR:   rd_data = r_list_addr;
            OFF_PORT:        rd_data = r_port;
            OFF_MODE:        rd_data = r_mode;
            OFF_SETUP_STAT:  rd_data = r_setup_stat;
            OFF_EP_STATUS:   rd_data = r_ep_status;
            OFF_EP_COMPLETE: rd_data = r_ep_complete;
            OFF_EP_CTRL0:    rd_data = r_ep_ctrl0;
            OFF_EP_CTRL1:    rd_data = r_ep_ctrl1;
            OFF_EP_CTRL2:    rd_data = r_ep_ctrl2;
            default:         rd_data = '0;
        endcase
    end

    // Next state and result for the current word.
    always_comb begin
        n_command     = r_command;
        n_status      = r_status;
        n_int_enable  = r_int_enable;
        n_list_addr   = r_list_addr;
        n_port        = r_port;
        n_mode        = r_mode;
        n_setup_stat  = r_setup_stat;
        n_ep_status   = r_ep_status;
        n_ep_complete = r_ep_complete;
        n_ep_ctrl0    = r_ep_ctrl0;
        n_ep_ctrl1    = r_ep_ctrl1;
        n_ep_ctrl2    = r_ep_ctrl2;
        n_running     = r_running;
        n_attached    = r_attached;
        res           = '0;

        case (i_item.cmd)
            CMD_READ: begin
                res.rdata = rd_data;
            end
            CMD_WRITE: begin
                case (i_item.reg_offset)
                    OFF_COMMAND: begin
                        n_command = i_item.wdata;
                        if (i_item.wdata[1]) begin
                            // Soft reset: everything but the attach state.
                            n_command     = COMMAND_RESET;
                            n_status      = '0;
                            n_int_enable  = '0;
                            n_list_addr   = '0;
                            n_port        = PORT_DEFAULT;
                            n_mode        = MODE_RESET;
                            n_setup_stat  = '0;
                            n_ep_status   = '0;
                            n_ep_complete = '0;
                            n_ep_ctrl0    = EP_CTRL0_RESET;
                            n_ep_ctrl1    = '0;
                            n_ep_ctrl2    = '0;
                            n_running     = 1'b0;
                        end else if (i_item.wdata[0] != r_running) begin
                            n_running = i_item.wdata[0];
                            if (i_item.wdata[0] && r_attached) begin
                                n_port   = r_port | PORT_CONNECT;
                                n_status = r_status | STATUS_PORT_CHG;
                            end
                        end
                    end
                    OFF_STATUS: begin
                        n_status = (r_status & ~status_wmask & ~STATUS_LOAD_BIT)
                                 | (status_wmask & STATUS_LOAD_BIT);
                        res.attach_ack = link_up && status_wmask[2];
                    end
                    OFF_INT_ENABLE: n_int_enable = i_item.wdata;
                    OFF_LIST_ADDR:  n_list_addr  = i_item.wdata;
                    OFF_PORT: begin
                        n_port = (i_item.wdata & ~PORT_RO_MASK) | (r_port & PORT_RO_MASK);
                    end
                    OFF_MODE:       n_mode       = i_item.wdata;
                    OFF_SETUP_STAT: n_setup_stat = r_setup_stat & ~i_item.wdata;
                    OFF_PRIME: begin
                        if (!link_up) begin
                            res.prime_refused = 1'b1;
                        end else begin
                            n_ep_status       = r_ep_status | (i_item.wdata & EP_RX_MASK);
                            n_ep_complete     = r_ep_complete | (i_item.wdata & EP_TX_MASK);
                            res.prime_tx_mask = i_item.wdata[22:16];
                            res.prime_rx_mask = i_item.wdata[6:0];
                            n_status          = r_status | STATUS_USB_INT;
                        end
                    end
                    OFF_FLUSH:       n_ep_status   = r_ep_status & ~i_item.wdata;
                    OFF_EP_COMPLETE: n_ep_complete = r_ep_complete & ~i_item.wdata;
                    OFF_EP_CTRL0: begin
                        n_ep_ctrl0 = (i_item.wdata & ~CTRL0_RO_MASK)
                                   | (r_ep_ctrl0 & CTRL0_RO_MASK);
                    end
                    OFF_EP_CTRL1: n_ep_ctrl1 = i_item.wdata;
                    OFF_EP_CTRL2: n_ep_ctrl2 = i_item.wdata;
                    default: ;
                endcase
            end
            CMD_ATTACH: begin
                n_attached = 1'b1;
                if (r_running) begin
                    n_port   = r_port | PORT_CONNECT;
                    n_status = r_status | STATUS_PORT_CHG;
                end
            end
            CMD_DETACH: begin
                n_attached = 1'b0;
                if (r_running) begin
                    n_port   = PORT_DEFAULT;
                    n_status = r_status | STATUS_PORT_CHG;
                end
            end
            CMD_SETUP: begin
                res.empty_ctrl_reply = (i_item.endpoint != 4'd0);
                res.setup_valid      = 1'b1;
                res.setup_address    = r_list_addr + SETUP_OFFSET;
                res.setup_word_lo    = {i_item.setup_value, i_item.request_code,
                                        i_item.req_type};
                res.setup_word_hi    = {i_item.setup_length, i_item.setup_index};
                n_setup_stat         = r_setup_stat | STATUS_USB_INT;
                n_status             = r_status | STATUS_USB_INT;
            end
            CMD_DATA_OUT: begin
                n_ep_complete = r_ep_complete | (32'd1 << i_item.endpoint);
                n_ep_status   = r_ep_status & ~EP_RX_MASK;
                n_status      = r_status | STATUS_USB_INT;
            end
            default: ;
        endcase

        // Interrupt level after the word has taken effect.
        res.irq = n_running && ((n_int_enable & n_status) != '0);
    end

    assign o_result = res;

    // State registers, updated once per processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command     <= COMMAND_RESET;
            r_status      <= '0;
            r_int_enable  <= '0;
            r_list_addr   <= '0;
            r_port        <= PORT_DEFAULT;
            r_mode        <= MODE_RESET;
            r_setup_stat  <= '0;
            r_ep_status   <= '0;
            r_ep_complete <= '0;
            r_ep_ctrl0    <= EP_CTRL0_RESET;
            r_ep_ctrl1    <= '0;
            r_ep_ctrl2    <= '0;
            r_running     <= 1'b0;
            r_attached    <= 1'b0;
        end else if (i_fire) begin
            r_command     <= n_command;
            r_status      <= n_status;
            r_int_enable  <= n_int_enable;
            r_list_addr   <= n_list_addr;
            r_port        <= n_port;
            r_mode        <= n_mode;
            r_setup_stat  <= n_setup_stat;
            r_ep_status   <= n_ep_status;
            r_ep_complete <= n_ep_complete;
            r_ep_ctrl0    <= n_ep_ctrl0;
            r_ep_ctrl1    <= n_ep_ctrl1;
            r_ep_ctrl2    <= n_ep_ctrl2;
            r_running     <= n_running;
            r_attached    <= n_attached;
        end
    end

    // The running flag always mirrors the run bit of the command register.
    a_run_matches_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running == r_command[0])
        else $error("running flag differs from command run bit");

    // Read-only bits of endpoint control 0 never drop.
    a_ctrl0_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ep_ctrl0 & CTRL0_RO_MASK) == CTRL0_RO_MASK)
        else $error("endpoint control 0 read-only bits changed");

    // A refused prime never reports primed endpoints.
    a_prime_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.prime_refused |-> (res.prime_tx_mask == '0 && res.prime_rx_mask == '0))
        else $error("refused prime reports endpoints");

    // The setup address and the empty reply flag only appear with the setup valid flag.
    a_setup_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !res.setup_valid |-> (res.setup_address == '0 && !res.empty_ctrl_reply))
        else $error("setup fields driven without setup flag");

endmodule

`default_nettype wire

// ===== design/usb_device_controller_regs_top.sv =====
// Top level of the USB device controller register block.
// Stages: input register, then result register, from which a word's result is presented.
// Throughput: one word per cycle; the input register and the result register
// each stall only when the stage after them is full and not being drained.
// Reset: synchronous, active low; clears both stages and loads register defaults.
// Depends on usbdc_pkg and usbdc_regfile.
`default_nettype none

module usb_device_controller_regs_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [11:0] i_reg_offset,
    input  wire logic [31:0] i_wdata,
    input  wire logic [3:0]  i_endpoint,
    input  wire logic [7:0]  i_req_type,
    input  wire logic [7:0]  i_request_code,
    input  wire logic [15:0] i_setup_value,
    input  wire logic [15:0] i_setup_index,
    input  wire logic [15:0] i_setup_length,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_rdata,
    output logic             o_irq,
    output logic             o_attach_ack,
    output logic [6:0]       o_prime_tx_mask,
    output logic [6:0]       o_prime_rx_mask,
    output logic             o_prime_refused,
    output logic             o_setup_valid,
    output logic [31:0]      o_setup_address,
    output logic [31:0]      o_setup_word_lo,
    output logic [31:0]      o_setup_word_hi,
    output logic             o_empty_ctrl_reply
);
    import usbdc_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    advance;
    logic    in_fire;

    // The held word moves on when the result register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= '{cmd: i_cmd, reg_offset: i_reg_offset, wdata: i_wdata,
                      endpoint: i_endpoint, req_type: i_req_type,
                      request_code: i_request_code, setup_value: i_setup_value,
                      setup_index: i_setup_index, setup_length: i_setup_length};
        end
    end

    // Register file and its update logic.
    usbdc_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_rdata            = r_out.rdata;
    assign o_irq              = r_out.irq;
    assign o_attach_ack       = r_out.attach_ack;
    assign o_prime_tx_mask    = r_out.prime_tx_mask;
    assign o_prime_rx_mask    = r_out.prime_rx_mask;
    assign o_prime_refused    = r_out.prime_refused;
    assign o_setup_valid      = r_out.setup_valid;
    assign o_setup_address    = r_out.setup_address;
    assign o_setup_word_lo    = r_out.setup_word_lo;
    assign o_setup_word_hi    = r_out.setup_word_hi;
    assign o_empty_ctrl_reply = r_out.empty_ctrl_reply;

endmodule

`default_nettype wire
